/* hw/rtl/gce_pkg.sv */
// ----------------------------------------------------------------------------
// gce_pkg
// shared constants and sequencer states of the gini coefficient engine
// ----------------------------------------------------------------------------
package gce_pkg;

  localparam int unsigned GCE_STORE_DEPTH      = 1024;
  localparam int unsigned GCE_RESULT_FRAC_BITS = 16;
  localparam logic [31:0] GCE_SIGN_FLIP        = 32'h8000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCALE,
    ST_DEN,
    ST_ADDR_I,
    ST_GET_I,
    ST_ADDR_J,
    ST_GET_J,
    ST_DIV,
    ST_DONE
  } gce_state_t;

endpackage

/* hw/rtl/gce_ram.sv */
// ----------------------------------------------------------------------------
// gce_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module gce_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/gini_coefficient_engine.sv */
// ----------------------------------------------------------------------------
// gini_coefficient_engine
// collects a set of signed values and reports its gini coefficient
// ----------------------------------------------------------------------------
// channel  signals                                   handshake
// in       start, sample_value, is_last, busy        taken when start & !busy
// out      result_valid, gini_q16, value_count,      one-cycle strobe
//          dropped
//
// a non-last item leaves the block idle and ready for the next item. after the
// last item the block is busy: the pairwise sum of absolute differences reads
// the value ram once per pair and once per first value of a row, then a
// restoring divider yields one quotient bit per cycle.
// reset is synchronous and clears the count and drop flag; the ram needs no
// clearing. the receiver cannot stall; the result is shown for one cycle.
// ----------------------------------------------------------------------------
module gini_coefficient_engine
  import gce_pkg::*;
#(
  parameter int unsigned STORE_DEPTH      = GCE_STORE_DEPTH,
  parameter int unsigned RESULT_FRAC_BITS = GCE_RESULT_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] sample_value,
  input  logic               is_last,
  output logic               busy,
  output logic               result_valid,
  output logic [15:0]        gini_q16,
  output logic [10:0]        value_count,
  output logic               dropped
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned SW = 32 + CW;
  localparam int unsigned DW = SW + CW;
  localparam int unsigned BW = $clog2(RESULT_FRAC_BITS + 1);

  gce_state_t state, state_next;

  logic [CW-1:0] count;
  logic          overflow;
  logic [31:0]   min_key;
  logic [SW-1:0] key_sum;
  logic [SW-1:0] base_prod;
  logic [SW-1:0] ssum;
  logic [DW-1:0] den;
  logic [DW-1:0] acc;
  logic [CW-1:0] idx_i;
  logic [CW-1:0] idx_j;
  logic [31:0]   xi;
  logic [RESULT_FRAC_BITS-1:0] quot;
  logic [BW-1:0] bit_cnt;

  logic          accept;
  logic          room;
  logic [31:0]   key;
  logic [31:0]   base;
  logic [31:0]   rdata;
  logic [AW-1:0] raddr;
  logic [31:0]   diff;
  logic [DW:0]   rem_sh;
  logic          rem_ge;

  assign accept = start && !busy;
  assign room   = count < CW'(STORE_DEPTH);
  assign key    = sample_value ^ GCE_SIGN_FLIP;
  assign base   = min_key[31] ? GCE_SIGN_FLIP : min_key;
  assign diff   = (xi > rdata) ? (xi - rdata) : (rdata - xi);
  assign rem_sh = {acc, 1'b0};
  assign rem_ge = rem_sh >= {1'b0, den};

  // value store
  gce_ram #(
    .WIDTH(32),
    .DEPTH(STORE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (accept && room),
    .waddr(count[AW-1:0]),
    .wdata(key),
    .raddr(raddr),
    .rdata(rdata)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and read address
  always_comb begin
    state_next = state;
    raddr      = idx_j[AW-1:0];
    case (state)
      ST_IDLE: begin
        if (accept && is_last) state_next = ST_SETUP;
      end
      ST_SETUP: begin
        state_next = (count <= CW'(1)) ? ST_DONE : ST_SCALE;
      end
      ST_SCALE: begin
        state_next = (key_sum == base_prod) ? ST_DONE : ST_DEN;
      end
      ST_DEN:    state_next = ST_ADDR_I;
      ST_ADDR_I: begin
        raddr      = idx_i[AW-1:0];
        state_next = ST_GET_I;
      end
      ST_GET_I:  state_next = ST_ADDR_J;
      ST_ADDR_J: state_next = ST_GET_J;
      ST_GET_J: begin
        if (idx_j == count - CW'(1)) begin
          state_next = (idx_i + CW'(2) == count) ? ST_DIV : ST_ADDR_I;
        end else begin
          state_next = ST_ADDR_J;
        end
      end
      ST_DIV: begin
        if (bit_cnt == BW'(RESULT_FRAC_BITS - 1)) state_next = ST_DONE;
      end
      ST_DONE:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
    end else if (accept) begin
      if (room) count <= count + CW'(1);
      else      overflow <= 1'b1;
    end else if (state == ST_DONE) begin
      count    <= '0;
      overflow <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept && room) begin
          key_sum <= (count == '0) ? SW'(key) : key_sum + SW'(key);
          min_key <= (count == '0 || key < min_key) ? key : min_key;
        end
      end
      ST_SETUP: begin
        base_prod <= SW'(count * base);
        quot      <= '0;
      end
      ST_SCALE: begin
        ssum <= key_sum - base_prod;
      end
      ST_DEN: begin
        den   <= DW'(count * ssum);
        acc   <= '0;
        idx_i <= '0;
      end
      ST_GET_I: begin
        xi    <= rdata;
        idx_j <= idx_i + CW'(1);
      end
      ST_GET_J: begin
        acc <= acc + DW'(diff);
        if (idx_j == count - CW'(1)) idx_i <= idx_i + CW'(1);
        else                          idx_j <= idx_j + CW'(1);
        bit_cnt <= '0;
      end
      ST_DIV: begin
        acc     <= rem_ge ? DW'(rem_sh - {1'b0, den}) : DW'(rem_sh);
        quot    <= {quot[RESULT_FRAC_BITS-2:0], rem_ge};
        bit_cnt <= bit_cnt + BW'(1);
      end
      default: begin
      end
    endcase
  end

  // result ports
  assign busy         = state != ST_IDLE;
  assign result_valid = state == ST_DONE;
  assign gini_q16     = 16'(quot);
  assign value_count  = 11'(count);
  assign dropped      = overflow;

endmodule

/* sim/gini_coefficient_engine_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gini_coefficient_engine_tb
// self-checking bench for the gini coefficient engine
// ----------------------------------------------------------------------------
// sets of signed values are fed one item at a time. A local predictor keeps
// the open set, shifts and sorts it on the last item and computes the Q0.16
// coefficient exactly. Each result strobe is checked field by field against
// the oldest prediction. Directed sets cover the value extremes, single
// value sets, equal value sets, negative shifts and one store overflow. The
// random sets are mostly short, so the pairwise pass after each set stays cheap.
// ----------------------------------------------------------------------------
module gini_coefficient_engine_tb;
  import gce_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 6_000_000;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
  } sample_item_t;

  typedef struct packed {
    logic [15:0] gini;
    logic [10:0] count;
    logic        drop;
  } gini_result_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic signed [31:0] sample_value;
  logic               is_last;
  logic               busy;
  logic               result_valid;
  logic [15:0]        gini_q16;
  logic [10:0]        value_count;
  logic               dropped;

  sample_item_t pending_items[$];
  gini_result_t expected_results[$];
  logic [31:0]  open_set[$];
  logic         open_overflow;
  int unsigned  fail_count;
  int unsigned  items_taken;
  int unsigned  total_items;
  int unsigned  cycle_count;
  logic         item_taken;

  gini_coefficient_engine dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .sample_value (sample_value),
    .is_last      (is_last),
    .busy         (busy),
    .result_valid (result_valid),
    .gini_q16     (gini_q16),
    .value_count  (value_count),
    .dropped      (dropped)
  );

  // clock, 8 ns period
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // gini of the closed set, exact, truncated to Q0.16
  function automatic logic [15:0] set_gini(input logic [31:0] vals[$]);
    logic [31:0]  keys[$];
    logic [31:0]  low_key;
    logic [31:0]  shift_base;
    logic [63:0]  total;
    logic [63:0]  weighted;
    logic [63:0]  numer;
    logic [63:0]  denom;
    logic [127:0] quot;
    int unsigned  n;
    n = vals.size();
    if (n <= 1) return 16'd0;
    low_key = 32'hFFFF_FFFF;
    foreach (vals[i]) begin
      keys.push_back(vals[i] ^ GCE_SIGN_FLIP);
      if (keys[i] < low_key) low_key = keys[i];
    end
    shift_base = (low_key < GCE_SIGN_FLIP) ? low_key : GCE_SIGN_FLIP;
    foreach (keys[i]) keys[i] = keys[i] - shift_base;
    keys.sort();
    total    = '0;
    weighted = '0;
    foreach (keys[i]) begin
      total    = total + 64'(keys[i]);
      weighted = weighted + 64'(i + 1) * 64'(keys[i]);
    end
    if (total == 0) return 16'd0;
    numer = 2 * weighted - (64'(n) + 1) * total;
    denom = 64'(n) * total;
    quot  = ({64'd0, numer} << GCE_RESULT_FRAC_BITS) / {64'd0, denom};
    return quot[15:0];
  endfunction

  // add one accepted item to the open set, close it on the last item
  task automatic absorb_item(input sample_item_t it);
    gini_result_t res;
    if (open_set.size() < GCE_STORE_DEPTH) open_set.push_back(it.value);
    else open_overflow = 1'b1;
    if (it.last) begin
      res.gini  = set_gini(open_set);
      res.count = 11'(open_set.size());
      res.drop  = open_overflow;
      expected_results.push_back(res);
      open_set.delete();
      open_overflow = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic add_set(input logic [31:0] vals[$]);
    foreach (vals[i]) pending_items.push_back({vals[i], i == vals.size() - 1});
  endtask

  // random set: mostly short, with content of several shapes
  task automatic add_random_set();
    logic [31:0] vals[$];
    logic [31:0] same;
    int unsigned len;
    int unsigned shape;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8) len = 1;
    else if (pick < 90) len = $urandom_range(10, 2);
    else len = $urandom_range(40, 11);
    shape = $urandom_range(4);
    same  = $urandom();
    repeat (len) begin
      case (shape)
        0: vals.push_back($urandom());
        1: vals.push_back(32'($signed($urandom_range(2000)) - 1000));
        2: vals.push_back(($urandom_range(3) == 0) ? $urandom() : same);
        3: vals.push_back($urandom_range(255));
        default: vals.push_back({1'b1, 31'($urandom())});
      endcase
    end
    add_set(vals);
  endtask

  // acceptance and prediction at the rising edge
  always @(posedge clk) begin
    item_taken <= !rst && start && !busy;
    if (!rst && start && !busy) begin
      absorb_item(pending_items.pop_front());
      items_taken++;
    end
  end

  // result checking
  always @(posedge clk) begin
    gini_result_t want;
    if (!rst && result_valid) begin
      if (expected_results.size() == 0) begin
        $display("[%0t] unexpected result, gini 0x%0h", $realtime, gini_q16);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (gini_q16 !== want.gini) report_mismatch("gini_q16", 32'(gini_q16), 32'(want.gini));
        if (value_count !== want.count)
          report_mismatch("value_count", 32'(value_count), 32'(want.count));
        if (dropped !== want.drop) report_mismatch("dropped", 32'(dropped), 32'(want.drop));
      end
    end
  end

  // item driver, changes inputs at the falling edge
  always @(negedge clk) begin
    int unsigned idle_pct;
    if (!rst && (!start || item_taken)) begin
      if (items_taken < total_items / 3) idle_pct = 30;
      else if (items_taken < 2 * total_items / 3) idle_pct = 61;
      else idle_pct = 0;
      if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
        start        <= 1'b1;
        sample_value <= pending_items[0].value;
        is_last      <= pending_items[0].last;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [31:0] vals[$];
    start         = 1'b0;
    sample_value  = '0;
    is_last       = 1'b0;
    rst           = 1'b1;
    item_taken    = 1'b0;
    open_overflow = 1'b0;
    fail_count    = 0;
    items_taken   = 0;
    cycle_count   = 0;

    // directed sets: single value, extremes, equal values, negative shift
    add_set('{32'h8000_0000});
    add_set('{32'h8000_0000, 32'h7FFF_FFFF});
    add_set('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    add_set('{32'd0, 32'd0, 32'd0, 32'd0});
    add_set('{32'hFFFF_FFFF, 32'd5, 32'hFFFF_FFF0, 32'd100});
    add_set('{32'd0, 32'd0, 32'd0, 32'd1});
    add_set('{32'd1, 32'd2, 32'd3});
    // store overflow: depth plus two values, last two dropped
    vals.delete();
    repeat (GCE_STORE_DEPTH + 2) vals.push_back($urandom());
    add_set(vals);
    while (pending_items.size() < 1500) add_random_set();
    total_items = pending_items.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    wait (pending_items.size() == 0 && expected_results.size() == 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/gce_pkg.sv
hw/rtl/gce_ram.sv
hw/rtl/gini_coefficient_engine.sv
sim/gini_coefficient_engine_tb.sv
